### src/isv_pkg.sv
// Shared constants, types and codes for the integer string validator.
package isv_pkg;

  localparam int MAX_LEN = 12;
  // Count saturates at MAX_LEN + 1, so it must hold that value.
  localparam int CNT_W   = $clog2(MAX_LEN + 2);
  localparam int ACC_W   = 31;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

  localparam logic [ACC_W-1:0] LIMIT_TENTH = ACC_W'(214748364);
  localparam logic [3:0]       LIMIT_LAST  = 4'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_TRAIL  = 3'd3;
  localparam logic [2:0] PH_STOP   = 3'd4;

  typedef struct packed {
    logic [2:0]       phase;
    logic [ACC_W-1:0] acc;
    logic             digit_seen;
    logic [CNT_W-1:0] count;
    logic             range_fault;
    logic             char_fault;
  } scan_state_t;

  typedef struct packed {
    logic status;
    logic too_long;
    logic bad_character;
    logic no_digits;
    logic out_of_range;
  } scan_result_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:       PH_LEAD,
    acc:         '0,
    digit_seen:  1'b0,
    count:       '0,
    range_fault: 1'b0,
    char_fault:  1'b0
  };

endpackage

### src/isv_step.sv
// One character step of the scan: next state and the end-of-string status.
module isv_step
  import isv_pkg::*;
(
  input  scan_state_t  cur,
  input  logic [7:0]   char_code,
  input  logic         last_char,
  input  logic         empty_string,
  output scan_state_t  nxt,
  output scan_result_t res
);

  scan_state_t upd;
  logic        is_digit;
  logic [3:0]  digit;
  logic        fits;
  logic [34:0] acc_x10;
  logic        tl;
  logic        bad;
  logic        nod;
  logic        oor;

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit    = 4'(char_code - CH_ZERO);
  assign fits     = (cur.acc < LIMIT_TENTH) ||
                    ((cur.acc == LIMIT_TENTH) && (digit <= LIMIT_LAST));
  // acc * 10 as (acc << 3) + (acc << 1), plus the new digit
  assign acc_x10  = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} +
                    {31'd0, digit};

  always_comb begin
    upd = cur;
    if (!empty_string) begin
      if (cur.count <= CNT_MAX) begin
        upd.count = cur.count + 1'b1;
      end
      if (cur.phase < PH_STOP) begin
        if (char_code == CH_NUL) begin
          upd.phase = PH_STOP;
        end else if ((cur.phase == PH_LEAD) && (char_code == CH_SPACE)) begin
          upd.phase = PH_LEAD;
        end else if ((cur.phase == PH_LEAD) &&
                     ((char_code == CH_PLUS) || (char_code == CH_MINUS))) begin
          upd.phase = PH_SIGN;
        end else if ((cur.phase != PH_TRAIL) && is_digit) begin
          upd.digit_seen = 1'b1;
          if (fits) begin
            upd.acc   = acc_x10[ACC_W-1:0];
            upd.phase = PH_DIGITS;
          end else begin
            upd.range_fault = 1'b1;
            upd.phase       = PH_STOP;
          end
        end else if (char_code == CH_SPACE) begin
          upd.phase = PH_TRAIL;
        end else begin
          upd.char_fault = 1'b1;
          upd.phase      = PH_STOP;
        end
      end
    end
  end

  // An empty string reports clean; a range fault masks the character flags.
  always_comb begin
    tl  = 1'b0;
    bad = 1'b0;
    nod = 1'b0;
    oor = 1'b0;
    if (upd.count != '0) begin
      tl = upd.count > CNT_MAX;
      if (upd.range_fault) begin
        oor = 1'b1;
      end else begin
        bad = upd.char_fault;
        nod = !upd.digit_seen;
      end
    end
  end

  assign res.status        = tl | bad | nod | oor;
  assign res.too_long      = tl;
  assign res.bad_character = bad;
  assign res.no_digits     = nod;
  assign res.out_of_range  = oor;

  assign nxt = last_char ? SCAN_RESET : upd;

endmodule

### src/integer_string_validator.sv
// Top level of the integer string validator: input stage, scan state, result register.
//
//   channel  direction  payload                                   handshake
//   in_      input      char_code, last_char, empty_string        in_valid / in_ready
//   out_     output     status, too_long, bad_character,          out_valid / out_ready
//                       no_digits, out_of_range
//
// One character per cycle unless a waiting result stalls the stage: a transfer lands in
// the input stage, which then updates the scan state through one step of compare,
// shift-add and phase logic. The result of a string is captured in the result register
// as the stage passes on the character that ends the string.
// Reset (rst_n low, synchronous) clears the stage, the scan state and the result valid.
// A waiting result stalls only the stage that holds the next last character.
module integer_string_validator
  import isv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  input  logic       in_empty_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_status,
  output logic       out_too_long,
  output logic       out_bad_character,
  output logic       out_no_digits,
  output logic       out_out_of_range
);

  logic         stg_valid_r;
  logic [7:0]   stg_char_r;
  logic         stg_last_r;
  logic         stg_empty_r;
  scan_state_t  state_r;
  scan_state_t  state_nxt;
  scan_result_t res_nxt;
  scan_result_t res_r;
  logic         out_valid_r;
  logic         stg_go;
  logic         in_xfer;

  isv_step u_step (
    .cur          (state_r),
    .char_code    (stg_char_r),
    .last_char    (stg_last_r),
    .empty_string (stg_empty_r),
    .nxt          (state_nxt),
    .res          (res_nxt)
  );

  // Advance the stage unless it carries a last character and the result is held.
  assign stg_go   = stg_valid_r && (!stg_last_r || !out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || stg_go;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      state_r     <= SCAN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        stg_valid_r <= 1'b1;
      end else if (stg_go) begin
        stg_valid_r <= 1'b0;
      end
      if (stg_go) begin
        state_r <= state_nxt;
      end
      if (stg_go && stg_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_char_r  <= in_char_code;
      stg_last_r  <= in_last_char;
      stg_empty_r <= in_empty_string;
    end
    if (stg_go && stg_last_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_too_long      = res_r.too_long;
  assign out_bad_character = res_r.bad_character;
  assign out_no_digits     = res_r.no_digits;
  assign out_out_of_range  = res_r.out_of_range;

endmodule

### bench/integer_string_validator_tb.sv
// Testbench for the integer string validator: directed table, then random strings.
`timescale 1ns / 100ps

module integer_string_validator_tb
  import isv_pkg::*;
();

  localparam int NUM_DIRECTED = 27;
  localparam int RANDOM_CHARS = 1450;
  localparam int CALM_CHARS   = 1300;
  localparam int HOLD_CHARS   = 400;
  localparam int DRAIN_CHARS  = 800;
  localparam int LONG_HOLD    = 60;
  localparam int TAIL_CYCLES  = 8;
  localparam int CYCLE_LIMIT  = 200000;

  localparam scan_result_t RES_OK        = '0;
  localparam scan_result_t RES_RANGE     = '{status: 1'b1, too_long: 1'b0, bad_character: 1'b0,
                                             no_digits: 1'b0, out_of_range: 1'b1};
  localparam scan_result_t RES_BAD_CHAR  = '{status: 1'b1, too_long: 1'b0, bad_character: 1'b1,
                                             no_digits: 1'b1, out_of_range: 1'b0};
  localparam scan_result_t RES_NO_DIGITS = '{status: 1'b1, too_long: 1'b0, bad_character: 1'b0,
                                             no_digits: 1'b1, out_of_range: 1'b0};

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       empty;
  } char_item_t;

  typedef struct packed {
    logic [7:0]   code;
    logic         last;
    logic         empty;
    logic         typed;
    scan_result_t want;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char_code;
  logic       in_last_char;
  logic       in_empty_string;
  logic       out_valid;
  logic       out_ready;
  logic       out_status;
  logic       out_too_long;
  logic       out_bad_character;
  logic       out_no_digits;
  logic       out_out_of_range;

  scan_state_t  tracker;
  scan_result_t expected_verdicts[$];
  int           errors;
  int           cycle_count;
  bit           calm;
  bit           long_hold_req;

  // Directed strings, all but the last with a typed expectation: empty, top of range, just over it,
  // lone bad byte, lone zero byte, and empty items inside a signed string.
  dir_row_t dir_rows [NUM_DIRECTED] = '{
    '{8'h00,    1'b1, 1'b1, 1'b1, RES_OK},
    '{"2",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"1",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"4",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"7",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"4",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"8",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"3",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"6",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"4",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"7",      1'b1, 1'b0, 1'b1, RES_OK},
    '{"2",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"1",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"4",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"7",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"4",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"8",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"3",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"6",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"4",      1'b0, 1'b0, 1'b0, RES_OK},
    '{"8",      1'b1, 1'b0, 1'b1, RES_RANGE},
    '{8'hFF,    1'b1, 1'b0, 1'b1, RES_BAD_CHAR},
    '{CH_NUL,   1'b1, 1'b0, 1'b1, RES_NO_DIGITS},
    '{8'hA5,    1'b0, 1'b1, 1'b0, RES_OK},
    '{CH_MINUS, 1'b0, 1'b0, 1'b0, RES_OK},
    '{"9",      1'b0, 1'b0, 1'b0, RES_OK},
    '{8'h5A,    1'b1, 1'b1, 1'b0, RES_OK}
  };

  integer_string_validator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .in_last_char      (in_last_char),
    .in_empty_string   (in_empty_string),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_too_long      (out_too_long),
    .out_bad_character (out_bad_character),
    .out_no_digits     (out_no_digits),
    .out_out_of_range  (out_out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the scan tracker by one transfer; on the final item produce the verdict.
  task automatic predict_scan(input logic [7:0] code, input logic last, input logic empty,
                              output logic done, output scan_result_t verdict);
    logic       is_digit;
    logic [3:0] digit;
    done     = 1'b0;
    verdict  = RES_OK;
    is_digit = (code >= CH_ZERO) && (code <= CH_NINE);
    digit    = 4'(code - CH_ZERO);
    if (!empty) begin
      if (tracker.count <= CNT_MAX) tracker.count = tracker.count + 1'b1;
      if (tracker.phase < PH_STOP) begin
        if (code == CH_NUL) begin
          tracker.phase = PH_STOP;
        end else if (tracker.phase == PH_LEAD && code == CH_SPACE) begin
          // stay in leading spaces
        end else if (tracker.phase == PH_LEAD && (code == CH_PLUS || code == CH_MINUS)) begin
          tracker.phase = PH_SIGN;
        end else if (tracker.phase != PH_TRAIL && is_digit) begin
          tracker.digit_seen = 1'b1;
          if (tracker.acc < LIMIT_TENTH || (tracker.acc == LIMIT_TENTH && digit <= LIMIT_LAST)) begin
            tracker.acc   = ACC_W'(tracker.acc * 10 + digit);
            tracker.phase = PH_DIGITS;
          end else begin
            tracker.range_fault = 1'b1;
            tracker.phase       = PH_STOP;
          end
        end else if (code == CH_SPACE) begin
          tracker.phase = PH_TRAIL;
        end else begin
          tracker.char_fault = 1'b1;
          tracker.phase      = PH_STOP;
        end
      end
    end
    if (last) begin
      done = 1'b1;
      if (tracker.count != 0) begin
        verdict.too_long = tracker.count > CNT_MAX;
        if (tracker.range_fault) begin
          verdict.out_of_range = 1'b1;
        end else begin
          verdict.bad_character = tracker.char_fault;
          verdict.no_digits     = !tracker.digit_seen;
        end
      end
      verdict.status = verdict.too_long | verdict.bad_character | verdict.no_digits |
                       verdict.out_of_range;
      tracker = SCAN_RESET;
    end
  endtask

  // Offer one item, hold it until the transfer, then record what it should produce.
  task automatic send_item(input logic [7:0] code, input logic last, input logic empty,
                           input logic typed, input scan_result_t want);
    logic         done;
    scan_result_t verdict;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_char_code    <= code;
    in_last_char    <= last;
    in_empty_string <= empty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_scan(code, last, empty, done, verdict);
    if (done) expected_verdicts.push_back(typed ? want : verdict);
    @(negedge clk);
  endtask

  // Mostly well-formed numbers with random content; the rest broken, noise or empty.
  task automatic make_string(ref char_item_t seq[$]);
    logic [7:0] txt[$];
    string      top;
    int         kind;
    int         pos;
    seq  = {};
    kind = $urandom_range(0, 99);
    if (kind < 88) begin
      repeat ($urandom_range(0, 2)) txt.push_back(CH_SPACE);
      case ($urandom_range(0, 2))
        0: txt.push_back(CH_PLUS);
        1: txt.push_back(CH_MINUS);
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        // hover around the 31-bit limit
        top = $sformatf("%0d", LIMIT_TENTH - 1 + $urandom_range(0, 2));
        for (int i = 0; i < top.len(); i++) txt.push_back(top[i]);
        txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end else begin
        repeat ($urandom_range(0, 8)) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      repeat ($urandom_range(0, 2)) txt.push_back(CH_SPACE);
      if (kind >= 68 && txt.size() > 0) begin
        pos = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 2))
          0: txt[pos] = 8'($urandom_range(0, 255));
          1: txt[pos] = CH_NUL;
          default: txt.insert(pos, 8'($urandom_range(0, 255)));
        endcase
      end
    end else if (kind < 96) begin
      repeat ($urandom_range(1, 20)) txt.push_back(8'($urandom_range(0, 255)));
    end
    foreach (txt[i]) begin
      if ($urandom_range(0, 15) == 0)
        seq.push_back('{code: 8'($urandom_range(0, 255)), last: 1'b0, empty: 1'b1});
      seq.push_back('{code: txt[i], last: 1'b0, empty: 1'b0});
    end
    if (txt.size() == 0 || $urandom_range(0, 9) == 0)
      seq.push_back('{code: 8'($urandom_range(0, 255)), last: 1'b1, empty: 1'b1});
    else
      seq[seq.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    scan_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result transfer with no string pending");
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        check_field("status", want.status, out_status);
        check_field("too_long", want.too_long, out_too_long);
        check_field("bad_character", want.bad_character, out_bad_character);
        check_field("no_digits", want.no_digits, out_no_digits);
        check_field("out_of_range", want.out_of_range, out_out_of_range);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random ready bursts, one long hold on request, none in the calm part.
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    char_item_t seq[$];
    int         sent_chars;
    bit         hold_done;
    bit         drain_done;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_char_code    = '0;
    in_last_char    = 1'b0;
    in_empty_string = 1'b0;
    errors          = 0;
    cycle_count     = 0;
    calm            = 1'b0;
    long_hold_req   = 1'b0;
    tracker         = SCAN_RESET;
    sent_chars      = 0;
    hold_done       = 1'b0;
    drain_done      = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_item(dir_rows[i].code, dir_rows[i].last, dir_rows[i].empty, dir_rows[i].typed,
                dir_rows[i].want);

    while (sent_chars < RANDOM_CHARS) begin
      make_string(seq);
      foreach (seq[i]) begin
        send_item(seq[i].code, seq[i].last, seq[i].empty, 1'b0, RES_OK);
        if (!seq[i].empty) sent_chars++;
      end
      calm = sent_chars >= CALM_CHARS;
      if (!hold_done && sent_chars >= HOLD_CHARS) begin
        hold_done     = 1'b1;
        long_hold_req = 1'b1;
      end
      if (!drain_done && sent_chars >= DRAIN_CHARS) begin
        // pause the sender until every verdict has come back
        drain_done = 1'b1;
        in_valid <= 1'b0;
        do @(negedge clk); while (expected_verdicts.size() != 0);
      end
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (expected_verdicts.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/isv_pkg.sv
src/isv_step.sv
src/integer_string_validator.sv
bench/integer_string_validator_tb.sv
